// ===== sv/cpfa_pkg.sv =====
// shared types and constants for the colour palette find-or-add block
// no dependencies; imported by cpfa_ram users and the top level
package cpfa_pkg;

	localparam int ENTRIES_DEF = 256;
	localparam int CH_W        = 32;
	localparam int IDX_W       = 8;
	localparam int KIND_W      = 2;
	localparam int STAT_W      = 2;
	localparam int IN_DATA_W   = IDX_W + 4 * CH_W;
	localparam int OUT_DATA_W  = IDX_W + 4 * CH_W;

	typedef enum logic [KIND_W-1:0] {
		KIND_FIND  = 2'd0,
		KIND_SET   = 2'd1,
		KIND_FLUSH = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_FOUND = 2'd0,
		ST_ADDED = 2'd1,
		ST_FULL  = 2'd2,
		ST_DONE  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_PREV,
		S_WALK,
		S_COMMIT,
		S_RESULT
	} state_t;

	// red in the lowest bits
	typedef struct packed {
		logic [CH_W-1:0] alpha;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} colour_t;

endpackage

// ===== sv/cpfa_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
// no package dependencies
module cpfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/colour_palette_find_or_add.sv =====
// colour palette with a colour-to-index map, find-or-add / set / flush / read
// depends on cpfa_pkg and cpfa_ram
//
//  channel  | dir | tdata (low bit up)                        | tuser
//  ---------+-----+-------------------------------------------+--------
//  s_*      | in  | entry_index, red, green, blue, alpha      | kind
//  m_*      | out | slot, red_out, green_out, blue_out, alpha | status
//
// read entry reads only the addressed row; find, set and flush walk
// every palette row through the single ram read port, one row per cycle
// (a find hit stops the walk early)
// after reset a clearing pass writes all ENTRIES rows, one per cycle, before
// the first input transfer is taken
// one item is in work at a time; a finished result sits in the output
// register, so the next item can be taken while m_tready is low
module colour_palette_find_or_add #(
	parameter int ENTRIES = cpfa_pkg::ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// entry_index, red, green, blue, alpha
	input  logic [cpfa_pkg::IN_DATA_W-1:0]   s_tdata,
	// kind
	input  logic [cpfa_pkg::KIND_W-1:0]      s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// slot, red_out, green_out, blue_out, alpha_out
	output logic [cpfa_pkg::OUT_DATA_W-1:0]  m_tdata,
	// status
	output logic [cpfa_pkg::STAT_W-1:0]      m_tuser
);

	import cpfa_pkg::*;

	localparam int AW    = $clog2(ENTRIES);
	localparam int NW    = $clog2(ENTRIES + 1);
	localparam int ROW_W = $bits(colour_t) + 1;   // mapped flag on top of the colour
	localparam int IDX_N = 2 ** IDX_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);
	localparam logic [NW-1:0] FULL_CNT  = NW'(ENTRIES);
	localparam logic [AW:0]   WALK_END  = (AW + 1)'(ENTRIES);

	// entry_index folded into the palette range, worked out at elaboration
	typedef logic [AW-1:0] idx_tab_t [IDX_N];

	function automatic idx_tab_t build_idx_tab();
		idx_tab_t t;
		for (int i = 0; i < IDX_N; i++) begin
			t[i] = AW'(i % ENTRIES);
		end
		return t;
	endfunction

	localparam idx_tab_t IDX_TAB = build_idx_tab();

	// control state
	state_t           state_q, state_d;
	logic [AW:0]      cnt_q;          // clear sweep and walk read address
	logic [NW-1:0]    next_free_q;
	logic             cmp_v_s1;       // ram data of a walk read is valid
	logic [AW-1:0]    cmp_addr_s1;
	logic             m_tvalid_q;

	// item and result payload
	kind_t            kind_q;
	logic [AW-1:0]    idx_q;
	colour_t          col_q;
	colour_t          prev_q;
	logic [IDX_W-1:0] res_slot_q;
	status_t          res_stat_q;
	colour_t          res_col_q;
	logic [IDX_W-1:0] m_slot_q;
	status_t          m_stat_q;
	colour_t          m_col_q;

	// ram port
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [ROW_W-1:0] ram_wdata;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [ROW_W-1:0] ram_rdata;

	// decode
	kind_t            in_kind;
	colour_t          in_col;
	logic [AW-1:0]    in_idx;
	logic             rd_flag;
	colour_t          rd_col;
	logic             walk_cmp;
	logic             hit_col;
	logic             hit_prev;
	logic             find_hit;
	logic             walk_end;
	logic             out_free;
	logic             table_full;
	logic             walk_issue;
	logic             load_out;
	logic             in_needs_row;

	assign in_kind      = kind_t'(s_tuser);
	assign in_col       = colour_t'(s_tdata[IN_DATA_W-1:IDX_W]);
	assign in_idx       = IDX_TAB[s_tdata[IDX_W-1:0]];
	assign in_needs_row = (in_kind == KIND_SET) || (in_kind == KIND_READ);

	assign rd_flag    = ram_rdata[ROW_W-1];
	assign rd_col     = colour_t'(ram_rdata[ROW_W-2:0]);
	assign walk_cmp   = (state_q == S_WALK) && cmp_v_s1;
	assign hit_col    = rd_flag && (rd_col == col_q);
	assign hit_prev   = rd_flag && (rd_col == prev_q);
	assign find_hit   = walk_cmp && (kind_q == KIND_FIND) && hit_col;
	assign walk_end   = walk_cmp && (cmp_addr_s1 == LAST_ADDR);
	assign out_free   = !m_tvalid_q || m_tready;
	assign table_full = (next_free_q == FULL_CNT);

	cpfa_ram #(
		.WIDTH(ROW_W),
		.DEPTH(ENTRIES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (cnt_q[AW-1:0] == LAST_ADDR) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid) state_d = in_needs_row ? S_PREV : S_WALK;
			end
			S_PREV: begin
				state_d = (kind_q == KIND_READ) ? S_RESULT : S_WALK;
			end
			S_WALK: begin
				priority if (find_hit) begin
					state_d = S_RESULT;
				end else if (walk_end) begin
					state_d = (kind_q == KIND_FLUSH) ? S_RESULT : S_COMMIT;
				end
			end
			S_COMMIT: begin
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// fsm outputs: handshake and ram control
	always_comb begin
		s_tready   = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = cmp_addr_s1;
		ram_wdata  = '0;
		ram_re     = 1'b0;
		ram_raddr  = cnt_q[AW-1:0];
		walk_issue = 1'b0;
		load_out   = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q[AW-1:0];
			end
			S_IDLE: begin
				s_tready  = 1'b1;
				ram_re    = s_tvalid && in_needs_row;
				ram_raddr = in_idx;
			end
			S_PREV: begin
			end
			S_WALK: begin
				walk_issue = (cnt_q != WALK_END);
				ram_re     = walk_issue;
				// row read last cycle is written back while the next one is read
				if (walk_cmp && (kind_q == KIND_SET) && (hit_col || hit_prev)) begin
					ram_we    = 1'b1;
					ram_wdata = {1'b0, rd_col};
				end
				if (walk_cmp && (kind_q == KIND_FLUSH) && rd_flag) begin
					ram_we = 1'b1;
				end
			end
			S_COMMIT: begin
				if ((kind_q == KIND_FIND) && !table_full) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(next_free_q);
					ram_wdata = {1'b1, col_q};
				end
				if (kind_q == KIND_SET) begin
					ram_we    = 1'b1;
					ram_waddr = idx_q;
					ram_wdata = {1'b1, col_q};
				end
			end
			S_RESULT: begin
				load_out = out_free;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			next_free_q <= '0;
			cmp_v_s1    <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			cmp_v_s1 <= walk_issue;
			if (state_q == S_CLEAR || walk_issue) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (s_tvalid && s_tready) begin
				cnt_q <= '0;
			end
			if (state_q == S_WALK && walk_end && !find_hit && kind_q == KIND_FLUSH) begin
				next_free_q <= '0;
			end
			if (state_q == S_COMMIT && kind_q == KIND_FIND && !table_full) begin
				next_free_q <= next_free_q + 1'b1;
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cmp_addr_s1 <= cnt_q[AW-1:0];
		if (s_tvalid && s_tready) begin
			kind_q <= in_kind;
			idx_q  <= in_idx;
			col_q  <= in_col;
		end
		if (state_q == S_PREV) begin
			prev_q     <= rd_col;
			res_col_q  <= rd_col;
			res_slot_q <= IDX_W'(idx_q);
			res_stat_q <= ST_DONE;
		end
		if (find_hit) begin
			res_slot_q <= IDX_W'(cmp_addr_s1);
			res_stat_q <= ST_FOUND;
			res_col_q  <= '0;
		end else if (walk_end && kind_q == KIND_FLUSH) begin
			res_slot_q <= '0;
			res_stat_q <= ST_DONE;
			res_col_q  <= '0;
		end
		if (state_q == S_COMMIT) begin
			res_col_q <= '0;
			if (kind_q == KIND_SET) begin
				res_slot_q <= IDX_W'(idx_q);
				res_stat_q <= ST_DONE;
			end else if (table_full) begin
				res_slot_q <= '0;
				res_stat_q <= ST_FULL;
			end else begin
				res_slot_q <= IDX_W'(next_free_q);
				res_stat_q <= ST_ADDED;
			end
		end
		if (load_out) begin
			m_slot_q <= res_slot_q;
			m_stat_q <= res_stat_q;
			m_col_q  <= res_col_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {m_col_q, m_slot_q};
	assign m_tuser  = m_stat_q;

	// checks

	// the free counter never runs past the palette size
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q <= FULL_CNT)
		else $error("next_free beyond palette size");

	// a write-back never lands on the row being read in the same cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("ram read and write at the same row");

	// an add moves the free counter by exactly one
	a_add_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMMIT && kind_q == KIND_FIND && !table_full)
		|=> (next_free_q == NW'($past(next_free_q) + 1'b1)))
		else $error("add did not advance next_free");

	// a full report carries slot zero
	a_full_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_FULL) |-> (m_tdata[IDX_W-1:0] == '0))
		else $error("table full result with nonzero slot");

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the colour palette find-or-add block
// drives op transfers, predicts every reply from its own palette copy, checks in order
// depends on cpfa_pkg and the colour_palette_find_or_add rtl
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cpfa_pkg::*;

	localparam int NSLOTS         = ENTRIES_DEF;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_REPORTS    = 10;

	// one op as the sender sees it
	typedef struct {
		kind_t      kind;
		logic [7:0] index;
		colour_t    colour;
	} palette_op_t;

	// one reply as the receiver sees it
	typedef struct {
		logic [7:0] slot;
		status_t    status;
		colour_t    colour;
	} palette_reply_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// entry_index, red, green, blue, alpha
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	// kind
	logic [KIND_W-1:0]     s_tuser  = KIND_FIND;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// slot, red_out, green_out, blue_out, alpha_out
	logic [OUT_DATA_W-1:0] m_tdata;
	// status
	logic [STAT_W-1:0]     m_tuser;

	colour_palette_find_or_add #(
		.ENTRIES(NSLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// palette shadow: the colour of every slot, its map flag, and the add
	// pointer; all start out zero, matching the clearing pass after reset
	// ---------------------------------------------------------------------
	colour_t    shadow_colour [NSLOTS];
	logic       shadow_mapped [NSLOTS];
	logic [8:0] shadow_next_free = '0;

	initial begin
		for (int s = 0; s < NSLOTS; s++) begin
			shadow_colour[s] = '0;
			shadow_mapped[s] = 1'b0;
		end
	end

	// apply one op to the shadow palette and return the reply it must produce
	function automatic palette_reply_t predict_palette_reply(palette_op_t op);
		palette_reply_t r;
		logic           hit;
		colour_t        prev;
		r.slot   = '0;
		r.status = ST_DONE;
		r.colour = '0;
		case (op.kind)
			KIND_FIND: begin
				// lowest mapped slot with the exact same four patterns wins
				hit = 1'b0;
				for (int s = 0; s < NSLOTS; s++) begin
					if (!hit && shadow_mapped[s] && shadow_colour[s] == op.colour) begin
						hit    = 1'b1;
						r.slot = s[7:0];
					end
				end
				if (hit) begin
					r.status = ST_FOUND;
				end else if (shadow_next_free == NSLOTS) begin
					// table full: nothing changes, slot reads zero
					r.status = ST_FULL;
				end else begin
					// add overwrites the slot; its old mapping simply goes away
					r.slot                               = shadow_next_free[7:0];
					shadow_colour[shadow_next_free[7:0]] = op.colour;
					shadow_mapped[shadow_next_free[7:0]] = 1'b1;
					shadow_next_free                     = shadow_next_free + 1'b1;
					r.status                             = ST_ADDED;
				end
			end
			KIND_SET: begin
				// drop whatever maps the slot's old colour, then the new colour
				prev = shadow_colour[op.index];
				for (int s = 0; s < NSLOTS; s++) begin
					if (shadow_mapped[s] && shadow_colour[s] == prev)
						shadow_mapped[s] = 1'b0;
				end
				for (int s = 0; s < NSLOTS; s++) begin
					if (shadow_mapped[s] && shadow_colour[s] == op.colour)
						shadow_mapped[s] = 1'b0;
				end
				shadow_colour[op.index] = op.colour;
				shadow_mapped[op.index] = 1'b1;
				r.slot                  = op.index;
			end
			KIND_FLUSH: begin
				// only mapped slots are zeroed, unmapped ones keep their data
				for (int s = 0; s < NSLOTS; s++) begin
					if (shadow_mapped[s]) begin
						shadow_colour[s] = '0;
						shadow_mapped[s] = 1'b0;
					end
				end
				shadow_next_free = '0;
			end
			default: begin
				r.colour = shadow_colour[op.index];
				r.slot   = op.index;
			end
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// stimulus list, filled once at time zero
	// ---------------------------------------------------------------------
	palette_op_t    palette_ops_pending [$];
	palette_reply_t palette_replies_due [$];
	colour_t        colour_pool [$];
	colour_t        added_colours [$];

	int unsigned ops_total    = 0;
	int unsigned ops_accepted = 0;
	int unsigned replies_seen = 0;
	int unsigned mismatches   = 0;
	int unsigned unexpected   = 0;
	int unsigned kind_count   [4];
	int unsigned status_count [4];

	function automatic colour_t random_colour();
		colour_t c;
		c.red   = $urandom;
		c.green = $urandom;
		c.blue  = $urandom;
		c.alpha = $urandom;
		return c;
	endfunction

	// half the time a colour from a small pool, so hits and remaps happen often
	function automatic colour_t mixed_colour();
		colour_t c;
		if ($urandom_range(0, 1) == 0)
			c = colour_pool[$urandom_range(0, colour_pool.size() - 1)];
		else
			c = random_colour();
		return c;
	endfunction

	// mostly low slots, the rest anywhere
	function automatic logic [7:0] mixed_index();
		logic [7:0] idx;
		if ($urandom_range(0, 9) < 7)
			idx = 8'($urandom_range(0, 15));
		else
			idx = 8'($urandom_range(0, NSLOTS - 1));
		return idx;
	endfunction

	function automatic void queue_op(kind_t kind, logic [7:0] index, colour_t colour);
		palette_op_t op;
		op.kind   = kind;
		op.index  = index;
		op.colour = colour;
		palette_ops_pending.push_back(op);
	endfunction

	// ---------------------------------------------------------------------
	// sender: bursts of transfers with random gaps, gaps counted from the
	// moment the input side is free so they land on every phase of a walk
	// ---------------------------------------------------------------------
	palette_op_t cur_op;
	int          burst_left = 0;
	int          gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			s_tuser    <= KIND_FIND;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				// transfer taken: predict its reply now, the block works in order
				palette_replies_due.push_back(predict_palette_reply(cur_op));
				status_count[palette_replies_due[$].status]++;
				kind_count[cur_op.kind]++;
				ops_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (palette_ops_pending.size() > 0) begin
					cur_op = palette_ops_pending.pop_front();
					s_tdata  <= {cur_op.colour, cur_op.index};
					s_tuser  <= cur_op.kind;
					s_tvalid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 11);
						case ($urandom_range(0, 3))
							0: gap_left = 0;
							1: gap_left = $urandom_range(1, 8);
							2: gap_left = $urandom_range(1, 40);
							default: gap_left = $urandom_range(1, 300);
						endcase
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// receiver: ready follows a random 16-bit pattern, stepped through bit by
	// bit and renewed when its phase wraps; some patterns never stall, some hold a long stall
	// ---------------------------------------------------------------------
	logic [15:0] stall_pattern = 16'hffff;
	logic [3:0]  stall_phase   = '0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready      <= 1'b0;
			stall_pattern = 16'hffff;
			stall_phase   = '0;
		end else begin
			if (stall_phase == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pattern = 16'hffff;
					1: stall_pattern = 16'($urandom);
					2: stall_pattern = 16'($urandom) | 16'($urandom);
					default: stall_pattern = 16'h00ff << $urandom_range(0, 8);
				endcase
			end
			m_tready    <= stall_pattern[stall_phase];
			stall_phase = stall_phase + 1'b1;
		end
	end

	// ---------------------------------------------------------------------
	// monitor: every reply transfer is checked against the oldest prediction
	// ---------------------------------------------------------------------
	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("reply %0d %s: expected %h, got %h", replies_seen, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		palette_reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (palette_replies_due.size() == 0) begin
				unexpected++;
				if (unexpected <= MAX_REPORTS)
					$display("reply transfer with nothing outstanding: tdata %h tuser %h",
						m_tdata, m_tuser);
			end else begin
				want = palette_replies_due.pop_front();
				check_field("slot", 32'(want.slot), 32'(m_tdata[7:0]));
				check_field("status", 32'(want.status), 32'(m_tuser));
				check_field("red_out", want.colour.red, m_tdata[8 +: CH_W]);
				check_field("green_out", want.colour.green, m_tdata[8 + CH_W +: CH_W]);
				check_field("blue_out", want.colour.blue, m_tdata[8 + 2 * CH_W +: CH_W]);
				check_field("alpha_out", want.colour.alpha, m_tdata[8 + 3 * CH_W +: CH_W]);
			end
			replies_seen++;
		end
	end

	// watchdog: too long without any transfer on either side means a hang
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("no transfer for %0d cycles, %0d of %0d ops taken, %0d replies due",
					quiet_cycles, ops_accepted, ops_total, palette_replies_due.size());
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// stimulus and end of run
	// ---------------------------------------------------------------------
	initial begin
		colour_t ones;
		colour_t stripe;
		colour_t c_a;
		colour_t c_b;
		colour_t c_c;
		colour_t c_d;
		colour_t c;
		int      fresh;
		int      pick;
		int      leftover;

		ones   = '1;
		stripe = {32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa};
		c_a    = random_colour();
		c_b    = random_colour();
		c_c    = random_colour();
		c_d    = random_colour();
		colour_pool.push_back('0);
		colour_pool.push_back(ones);
		colour_pool.push_back(stripe);
		for (int i = 0; i < 5; i++)
			colour_pool.push_back(random_colour());

		// directed: reads of a fresh palette, add and hit, all-zero and all-one
		// colours, a set that steals a mapping, a set whose old colour unmaps
		// another slot, flush keeping unmapped data, add over a mapped slot
		queue_op(KIND_READ, 8'd0, ones);
		queue_op(KIND_READ, 8'd255, '0);
		queue_op(KIND_FIND, 8'd255, '0);
		queue_op(KIND_FIND, 8'd0, '0);
		queue_op(KIND_FIND, 8'd0, ones);
		queue_op(KIND_FIND, 8'd0, stripe);
		queue_op(KIND_SET, 8'd10, c_a);
		queue_op(KIND_SET, 8'd20, c_a);
		queue_op(KIND_FIND, 8'd0, c_a);
		queue_op(KIND_SET, 8'd10, c_b);
		queue_op(KIND_FIND, 8'd0, c_a);
		queue_op(KIND_SET, 8'd255, ones);
		queue_op(KIND_FIND, 8'd0, ones);
		queue_op(KIND_SET, 8'd0, ones);
		queue_op(KIND_READ, 8'd255, '0);
		queue_op(KIND_READ, 8'd10, '0);
		queue_op(KIND_FLUSH, 8'd77, stripe);
		queue_op(KIND_READ, 8'd10, '0);
		queue_op(KIND_READ, 8'd20, '0);
		queue_op(KIND_READ, 8'd255, '0);
		queue_op(KIND_FIND, 8'd0, stripe);
		queue_op(KIND_SET, 8'd1, c_c);
		queue_op(KIND_FIND, 8'd0, c_d);
		queue_op(KIND_FIND, 8'd0, c_c);

		// fill: flush, then add fresh colours past the table size so it runs
		// full, with hits on earlier adds mixed in along the way
		queue_op(KIND_FLUSH, 8'd0, '0);
		fresh = 0;
		while (fresh < NSLOTS + 6) begin
			if (added_colours.size() > 0 && $urandom_range(0, 9) == 0) begin
				queue_op(KIND_FIND, 8'($urandom), added_colours[$urandom_range(0,
					added_colours.size() - 1)]);
			end else begin
				c = random_colour();
				added_colours.push_back(c);
				queue_op(KIND_FIND, 8'($urandom), c);
				fresh++;
			end
		end
		// while full: a set maps a new colour and a find hits it, then a read of a random slot
		c = random_colour();
		queue_op(KIND_SET, 8'($urandom), c);
		queue_op(KIND_FIND, 8'd0, c);
		queue_op(KIND_SET, 8'd3, added_colours[7]);
		queue_op(KIND_FIND, 8'd0, added_colours[7]);
		queue_op(KIND_READ, 8'($urandom), '0);
		queue_op(KIND_FIND, 8'd0, random_colour());
		queue_op(KIND_FLUSH, 8'd0, '0);

		// random mix over a small colour pool and mostly low slots
		for (int i = 0; i < 110; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				queue_op(KIND_FIND, 8'($urandom), mixed_colour());
			else if (pick < 70)
				queue_op(KIND_SET, mixed_index(), mixed_colour());
			else if (pick < 95)
				queue_op(KIND_READ, mixed_index(), random_colour());
			else
				queue_op(KIND_FLUSH, 8'($urandom), random_colour());
		end
		ops_total = palette_ops_pending.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (ops_accepted < ops_total || palette_replies_due.size() != 0)
			@(posedge clk);
		// every op has a reply; give a stray one a walk's time to show up
		repeat (NSLOTS + 16) @(posedge clk);

		leftover = palette_replies_due.size();
		$display("ops: %0d find, %0d set, %0d flush, %0d read; %0d replies checked",
			kind_count[KIND_FIND], kind_count[KIND_SET], kind_count[KIND_FLUSH],
			kind_count[KIND_READ], replies_seen);
		$display("finds: %0d hits, %0d adds, %0d table full; %0d mismatches, %0d strays",
			status_count[ST_FOUND], status_count[ST_ADDED], status_count[ST_FULL],
			mismatches, unexpected + leftover);
		if (mismatches == 0 && unexpected == 0 && leftover == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
